[rtl/cae_pkg.sv]
package cae_pkg;

    // argument buffer geometry
    localparam int ARG_DEPTH = 64;
    localparam int ADDR_W    = $clog2(ARG_DEPTH);
    localparam int CNT_W     = $clog2(ARG_DEPTH + 1);

    // register widths
    localparam int IDX_W     = 8;
    localparam int LIM_W     = 7;
    localparam int CTR_W     = 9;
    localparam int CFG_SEL_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_SEL_W-1:0] CFG_ARG_INDEX = 2'd0;
    localparam logic [CFG_SEL_W-1:0] CFG_ARG_LIMIT = 2'd1;

    // reset values of the registers
    localparam logic [IDX_W-1:0] ARG_INDEX_RST = 8'd1;
    localparam logic [LIM_W-1:0] ARG_LIMIT_RST = 7'd64;

    // argument counter saturation
    localparam logic [CTR_W-1:0] CTR_MAX = '1;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // buffer write from the parser
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    // one finished parse, handed to the drain side
    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [CNT_W-1:0]  stop;
        logic              blank;
        logic              status;
    } job_t;

    // job queue status seen by the parser
    typedef struct packed {
        logic full;
        logic buf_job;
    } jobq_stat_t;

endpackage

[rtl/call_argument_extractor_core.sv]
// channel   direction  handshake              payload
// input     in         push / full            ch
// result    out        empty / pop            out_char, char_valid, last, status
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one character is taken per cycle while the text is parsed
// a finishing ')' or ',' stalls input until the drain has read the last
// non-blank character: one result per cycle while popped, one buffer read port
// empty and error results go through the job queue without stalling input
// reset clears the parse state, job queue and result register; no clearing pass
// result stalls back up through the job queue to full
module call_argument_extractor_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      ch,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_char,
    output logic                            char_valid,
    output logic                            last,
    output logic                            status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cae_pkg::CFG_SEL_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    cae_pkg::buf_wr_t     buf_wr;
    cae_pkg::job_t        job_in;
    cae_pkg::job_t        job_head;
    cae_pkg::jobq_stat_t  qstat;
    logic                 job_push;
    logic                 job_pop;
    logic                 job_valid;
    logic                 draining;
    logic                 hold;

    // parser holds on a full queue or while the buffer is still owed to drain
    assign hold = qstat.full || qstat.buf_job || draining;

    cae_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ch        (ch),
        .hold      (hold),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .buf_wr    (buf_wr),
        .job_push  (job_push),
        .job_data  (job_in)
    );

    cae_jobq u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_data  (job_head),
        .stat     (qstat)
    );

    cae_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .buf_wr     (buf_wr),
        .job_valid  (job_valid),
        .job        (job_head),
        .job_pop    (job_pop),
        .draining   (draining),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .char_valid (char_valid),
        .last       (last),
        .status     (status)
    );

    // the buffer is never written while a drain may still read it
    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        buf_wr.en |-> !(draining || qstat.buf_job))
        else $error("buffer written during drain");

endmodule

[rtl/cae_front.sv]
module cae_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [7:0]                      ch,
    input  logic                            hold,
    output logic                            full,
    input  logic                            cfg_valid,
    input  logic [cae_pkg::CFG_SEL_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output logic                            cfg_ready,
    output cae_pkg::buf_wr_t                buf_wr,
    output logic                            job_push,
    output cae_pkg::job_t                   job_data
);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_NORMAL,
        PH_DQUOTE,
        PH_SQUOTE,
        PH_DONE
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [cae_pkg::IDX_W-1:0]       arg_index_reg;
    logic [cae_pkg::LIM_W-1:0]       arg_limit_reg;
    logic [cae_pkg::CTR_W-1:0]       arg_counter_reg, arg_counter_next;
    logic [cae_pkg::CNT_W-1:0]       fill_reg, fill_next;
    logic [cae_pkg::CNT_W-1:0]       first_reg, first_next;
    logic [cae_pkg::CNT_W-1:0]       lastnb_reg, lastnb_next;

    logic                            accept;
    logic                            selected;
    logic [cae_pkg::LIM_W-1:0]       lim;
    logic [cae_pkg::LIM_W-1:0]       cap;
    logic                            room;
    logic                            keep;
    logic                            finish;

    assign full      = hold;
    assign accept    = push && !hold;
    assign cfg_ready = 1'b1;

    // keep limit: buffer size clamped to the depth, minus one
    always_comb
    begin
        if (arg_limit_reg > cae_pkg::LIM_W'(cae_pkg::ARG_DEPTH))
        begin
            lim = cae_pkg::LIM_W'(cae_pkg::ARG_DEPTH);
        end
        else
        begin
            lim = arg_limit_reg;
        end
        cap = (lim == '0) ? '0 : lim - cae_pkg::LIM_W'(1);
    end

    assign selected = (arg_counter_reg == cae_pkg::CTR_W'(arg_index_reg));
    assign room     = (cae_pkg::LIM_W'(fill_reg) < cap);

    // character classification and parse state
    always_comb
    begin
        phase_next       = phase_reg;
        arg_counter_next = arg_counter_reg;
        fill_next        = fill_reg;
        first_next       = first_reg;
        lastnb_next      = lastnb_reg;
        keep             = 1'b0;
        finish           = 1'b0;
        job_push         = 1'b0;
        job_data.first   = first_reg[cae_pkg::ADDR_W-1:0];
        job_data.stop    = lastnb_reg;
        job_data.blank   = (lastnb_reg == '0) || (first_reg >= lastnb_reg);
        job_data.status  = cae_pkg::ST_OK;

        if (accept)
        begin
            if (ch == cae_pkg::CH_NUL)
            begin
                // terminator: report unless already finished, then clear the run
                if (phase_reg == PH_SEEK)
                begin
                    job_push       = 1'b1;
                    job_data.blank = 1'b1;
                end
                else if (phase_reg != PH_DONE)
                begin
                    job_push        = 1'b1;
                    job_data.blank  = 1'b1;
                    job_data.status = cae_pkg::ST_ERROR;
                end
                phase_next       = PH_SEEK;
                arg_counter_next = cae_pkg::CTR_W'(1);
                fill_next        = '0;
                first_next       = '0;
                lastnb_next      = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SEEK:
                    begin
                        if (ch == cae_pkg::CH_LPAREN)
                        begin
                            phase_next = PH_NORMAL;
                        end
                    end
                    PH_NORMAL:
                    begin
                        if (ch == cae_pkg::CH_RPAREN)
                        begin
                            finish = 1'b1;
                        end
                        else if (ch == cae_pkg::CH_DQUOTE)
                        begin
                            phase_next = PH_DQUOTE;
                        end
                        else if (ch == cae_pkg::CH_SQUOTE)
                        begin
                            phase_next = PH_SQUOTE;
                        end
                        else if (ch == cae_pkg::CH_COMMA)
                        begin
                            if (selected)
                            begin
                                finish = 1'b1;
                            end
                            else if (arg_counter_reg != cae_pkg::CTR_MAX)
                            begin
                                arg_counter_next = arg_counter_reg + cae_pkg::CTR_W'(1);
                            end
                        end
                        else
                        begin
                            keep = 1'b1;
                        end
                    end
                    PH_DQUOTE:
                    begin
                        if (ch == cae_pkg::CH_DQUOTE)
                        begin
                            phase_next = PH_NORMAL;
                        end
                        else
                        begin
                            keep = 1'b1;
                        end
                    end
                    PH_SQUOTE:
                    begin
                        if (ch == cae_pkg::CH_SQUOTE)
                        begin
                            phase_next = PH_NORMAL;
                        end
                        else
                        begin
                            keep = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (finish)
                begin
                    job_push   = 1'b1;
                    phase_next = PH_DONE;
                end

                // store a character of the selected argument
                if (keep && selected && room)
                begin
                    fill_next = fill_reg + cae_pkg::CNT_W'(1);
                    if ((ch != cae_pkg::CH_SPACE) && (ch != cae_pkg::CH_TAB))
                    begin
                        if (lastnb_reg == '0)
                        begin
                            first_next = fill_reg;
                        end
                        lastnb_next = fill_reg + cae_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

    assign buf_wr.en   = accept && (ch != cae_pkg::CH_NUL) && keep && selected && room;
    assign buf_wr.addr = fill_reg[cae_pkg::ADDR_W-1:0];
    assign buf_wr.data = ch;

    // parse state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEEK;
            arg_counter_reg <= cae_pkg::CTR_W'(1);
            fill_reg        <= '0;
            first_reg       <= '0;
            lastnb_reg      <= '0;
            arg_index_reg   <= cae_pkg::ARG_INDEX_RST;
            arg_limit_reg   <= cae_pkg::ARG_LIMIT_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            arg_counter_reg <= arg_counter_next;
            fill_reg        <= fill_next;
            first_reg       <= first_next;
            lastnb_reg      <= lastnb_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cae_pkg::CFG_ARG_INDEX: arg_index_reg <= cfg_data;
                    cae_pkg::CFG_ARG_LIMIT: arg_limit_reg <= cfg_data[cae_pkg::LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/cae_jobq.sv]
module cae_jobq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cae_pkg::job_t         wr_data,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output cae_pkg::job_t         rd_data,
    output cae_pkg::jobq_stat_t   stat
);

    // two-entry queue: one-bit pointers that toggle on each transfer
    cae_pkg::job_t   entry_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      count_reg, count_next;
    logic [1:0]      occ;

    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rptr_reg];

    // which slots are occupied
    always_comb
    begin
        occ = '0;
        if (count_reg == 2'd2)
        begin
            occ = '1;
        end
        else if (count_reg == 2'd1)
        begin
            occ[rptr_reg] = 1'b1;
        end
    end

    // queue full, and a queued job that still has to read the buffer
    assign stat.full    = (count_reg == 2'd2);
    assign stat.buf_job = (occ[0] && !entry_reg[0].blank) || (occ[1] && !entry_reg[1].blank);

    always_comb
    begin
        wptr_next  = wr_en ? !wptr_reg : wptr_reg;
        rptr_next  = rd_en ? !rptr_reg : rptr_reg;
        count_next = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    // no write into a full queue without a read
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && (count_reg == 2'd2) && !rd_en))
        else $error("job queue overflow");

endmodule

[rtl/cae_back.sv]
module cae_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cae_pkg::buf_wr_t      buf_wr,
    input  logic                  job_valid,
    input  cae_pkg::job_t         job,
    output logic                  job_pop,
    output logic                  draining,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_char,
    output logic                  char_valid,
    output logic                  last,
    output logic                  status
);

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } bstate_t;

    logic [7:0]                  mem [cae_pkg::ARG_DEPTH];

    bstate_t                     state_reg;
    logic [cae_pkg::ADDR_W-1:0]  ptr_reg;
    logic [cae_pkg::CNT_W-1:0]   stop_reg;
    logic                        out_valid_reg;
    logic [7:0]                  out_char_reg;
    logic                        char_valid_reg;
    logic                        last_reg;
    logic                        status_reg;

    logic                        pop_xfer;
    logic                        can_load;
    logic                        load_char;
    logic                        load_blank;
    logic [cae_pkg::ADDR_W-1:0]  rd_addr;
    logic [cae_pkg::CNT_W-1:0]   stop_sel;
    logic                        at_end;

    assign pop_xfer   = pop && out_valid_reg;
    assign can_load   = !out_valid_reg || pop_xfer;
    assign job_pop    = (state_reg == BK_IDLE) && can_load && job_valid;
    assign load_blank = job_pop && job.blank;
    assign load_char  = (job_pop && !job.blank) || ((state_reg == BK_DRAIN) && can_load);
    assign draining   = (state_reg == BK_DRAIN);

    // read address and end test for the character being loaded
    assign rd_addr  = (state_reg == BK_DRAIN) ? ptr_reg : job.first;
    assign stop_sel = (state_reg == BK_DRAIN) ? stop_reg : job.stop;
    assign at_end   = ((cae_pkg::CNT_W'(rd_addr) + cae_pkg::CNT_W'(1)) == stop_sel);

    // argument buffer
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
    end

    // result register: buffer read, or zero for an empty result
    always_ff @(posedge clk)
    begin
        if (load_char)
        begin
            out_char_reg <= mem[rd_addr];
        end
        else if (load_blank)
        begin
            out_char_reg <= '0;
        end
    end

    // drain sequencer and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            ptr_reg        <= '0;
            stop_reg       <= '0;
            out_valid_reg  <= 1'b0;
            char_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            status_reg     <= cae_pkg::ST_OK;
        end
        else
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    if (load_blank)
                    begin
                        out_valid_reg  <= 1'b1;
                        char_valid_reg <= 1'b0;
                        last_reg       <= 1'b1;
                        status_reg     <= job.status;
                    end
                    else if (load_char)
                    begin
                        out_valid_reg  <= 1'b1;
                        char_valid_reg <= 1'b1;
                        last_reg       <= at_end;
                        status_reg     <= cae_pkg::ST_OK;
                        ptr_reg        <= rd_addr + cae_pkg::ADDR_W'(1);
                        stop_reg       <= job.stop;
                        if (!at_end)
                        begin
                            state_reg <= BK_DRAIN;
                        end
                    end
                    else if (pop_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                BK_DRAIN:
                begin
                    if (load_char)
                    begin
                        out_valid_reg  <= 1'b1;
                        char_valid_reg <= 1'b1;
                        last_reg       <= at_end;
                        status_reg     <= cae_pkg::ST_OK;
                        ptr_reg        <= ptr_reg + cae_pkg::ADDR_W'(1);
                        if (at_end)
                        begin
                            state_reg <= BK_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    assign empty      = !out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign last       = last_reg;
    assign status     = status_reg;

    // the drain pointer stays inside the argument
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> (cae_pkg::CNT_W'(ptr_reg) < stop_reg))
        else $error("drain pointer past end of argument");

    // an empty result always closes the run
    a_blank_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !char_valid_reg) |-> last_reg)
        else $error("empty result not flagged last");

    // an error result never carries a character
    a_error_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == cae_pkg::ST_ERROR)) |-> !char_valid_reg)
        else $error("error result with a character");

endmodule

[dv/cae_arg_checker.sv]
`timescale 1ns / 1ps

module cae_arg_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [7:0]                    ch,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [7:0]                    out_char,
    input  logic                          char_valid,
    input  logic                          last,
    input  logic                          status,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cae_pkg::CFG_SEL_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            fail_count,
    output int                            pending
);

    typedef enum logic [2:0] {
        SCAN_OPEN,
        IN_ARGS,
        IN_DQUOTE,
        IN_SQUOTE,
        FINISHED
    } parse_phase_t;

    // one result as the block should present it
    typedef struct packed {
        logic [7:0] chr;
        logic       valid;
        logic       fin;
        logic       st;
    } arg_result_t;

    // shadow registers
    logic [cae_pkg::IDX_W-1:0] sel_index;
    logic [cae_pkg::LIM_W-1:0] size_limit;

    // shadow parse state
    parse_phase_t              phase;
    logic [cae_pkg::CTR_W-1:0] arg_num;
    logic [cae_pkg::CNT_W-1:0] kept;
    logic [cae_pkg::CNT_W-1:0] lead;
    logic [cae_pkg::CNT_W-1:0] tail;
    logic [7:0]                kept_chars [cae_pkg::ARG_DEPTH];

    // results still owed by the block, oldest first
    arg_result_t expected_args [$];

    // usable buffer size: limit clamped to the depth, one slot reserved
    function automatic int keep_limit();
        int lim;
        lim = int'(size_limit);
        if (lim > cae_pkg::ARG_DEPTH)
            lim = cae_pkg::ARG_DEPTH;
        return (lim != 0) ? lim - 1 : 0;
    endfunction

    task automatic restart_parse();
        phase   = SCAN_OPEN;
        arg_num = cae_pkg::CTR_W'(1);
        kept    = '0;
        lead    = '0;
        tail    = '0;
    endtask

    task automatic expect_result(input logic [7:0] c, input logic v, input logic f,
                                 input logic s);
        arg_result_t r;
        r.chr   = c;
        r.valid = v;
        r.fin   = f;
        r.st    = s;
        expected_args.push_back(r);
    endtask

    // keep a character of the selected argument, tracking the non-blank span
    task automatic store_char(input logic [7:0] c);
        if (arg_num == cae_pkg::CTR_W'(sel_index) && int'(kept) < keep_limit())
        begin
            kept_chars[kept[cae_pkg::ADDR_W-1:0]] = c;
            if (c != cae_pkg::CH_SPACE && c != cae_pkg::CH_TAB)
            begin
                if (tail == '0)
                    lead = kept;
                tail = kept + cae_pkg::CNT_W'(1);
            end
            kept = kept + cae_pkg::CNT_W'(1);
        end
    endtask

    // stripped argument, or a single empty success
    task automatic drain_arg();
        int i;
        if (tail == '0 || lead >= tail)
            expect_result(cae_pkg::CH_NUL, 1'b0, 1'b1, cae_pkg::ST_OK);
        else
            for (i = int'(lead); i < int'(tail); i++)
                expect_result(kept_chars[i], 1'b1, i == int'(tail) - 1, cae_pkg::ST_OK);
    endtask

    task automatic predict_char(input logic [7:0] c);
        if (c == cae_pkg::CH_NUL)
        begin
            // terminator: empty success before '(', error while still open
            if (phase == SCAN_OPEN)
                expect_result(cae_pkg::CH_NUL, 1'b0, 1'b1, cae_pkg::ST_OK);
            else if (phase != FINISHED)
                expect_result(cae_pkg::CH_NUL, 1'b0, 1'b1, cae_pkg::ST_ERROR);
            restart_parse();
        end
        else
        begin
            case (phase)
                SCAN_OPEN:
                    if (c == cae_pkg::CH_LPAREN)
                        phase = IN_ARGS;
                IN_ARGS:
                    if (c == cae_pkg::CH_RPAREN)
                    begin
                        drain_arg();
                        phase = FINISHED;
                    end
                    else if (c == cae_pkg::CH_DQUOTE)
                        phase = IN_DQUOTE;
                    else if (c == cae_pkg::CH_SQUOTE)
                        phase = IN_SQUOTE;
                    else if (c == cae_pkg::CH_COMMA)
                    begin
                        if (arg_num == cae_pkg::CTR_W'(sel_index))
                        begin
                            drain_arg();
                            phase = FINISHED;
                        end
                        else if (arg_num != cae_pkg::CTR_MAX)
                            arg_num = arg_num + cae_pkg::CTR_W'(1);
                    end
                    else
                        store_char(c);
                IN_DQUOTE:
                    if (c == cae_pkg::CH_DQUOTE)
                        phase = IN_ARGS;
                    else
                        store_char(c);
                IN_SQUOTE:
                    if (c == cae_pkg::CH_SQUOTE)
                        phase = IN_ARGS;
                    else
                        store_char(c);
                default: ;
            endcase
        end
    endtask

    // compare one result transfer against the oldest expectation
    task automatic check_result();
        arg_result_t want;
        logic        bad;
        bad = 1'b0;
        if (expected_args.size() == 0)
        begin
            $display("%0t: result with none expected: out_char %h char_valid %b",
                     $time, out_char, char_valid);
            $display("%0t: result with none expected: last %b status %b",
                     $time, last, status);
            fail_count++;
        end
        else
        begin
            want = expected_args.pop_front();
            if (out_char !== want.chr)
            begin
                $display("%0t: out_char expected %h actual %h", $time, want.chr, out_char);
                bad = 1'b1;
            end
            if (char_valid !== want.valid)
            begin
                $display("%0t: char_valid expected %b actual %b", $time, want.valid,
                         char_valid);
                bad = 1'b1;
            end
            if (last !== want.fin)
            begin
                $display("%0t: last expected %b actual %b", $time, want.fin, last);
                bad = 1'b1;
            end
            if (status !== want.st)
            begin
                $display("%0t: status expected %b actual %b", $time, want.st, status);
                bad = 1'b1;
            end
            if (bad)
                fail_count++;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_index  = cae_pkg::ARG_INDEX_RST;
            size_limit = cae_pkg::ARG_LIMIT_RST;
            fail_count = 0;
            restart_parse();
            expected_args.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                predict_char(ch);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cae_pkg::CFG_ARG_INDEX)
                    sel_index = cfg_data;
                else if (cfg_index == cae_pkg::CFG_ARG_LIMIT)
                    size_limit = cfg_data[cae_pkg::LIM_W-1:0];
            end
            pending <= expected_args.size();
        end
    end

endmodule

[dv/tb_call_argument_extractor_core.sv]
`timescale 1ns / 1ps

module tb_call_argument_extractor_core;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 8;

    // register indexes outside the list, written once to check they are ignored
    localparam logic [cae_pkg::CFG_SEL_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [cae_pkg::CFG_SEL_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Y = 8'h79;
    localparam logic [7:0] CH_MIN     = 8'h01;
    localparam logic [7:0] CH_MAX     = 8'hFF;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [7:0]                    ch;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [7:0]                    out_char;
    logic                          char_valid;
    logic                          last;
    logic                          status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [cae_pkg::CFG_SEL_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_cycles = 0;
    int idle_cycles = 0;

    // characters of the string being sent, terminator included
    logic [7:0] text [$];

    call_argument_extractor_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ch         (ch),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .char_valid (char_valid),
        .last       (last),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cae_arg_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ch         (ch),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .char_valid (char_valid),
        .last       (last),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen   <= hold_req;
            hold_cycles <= HOLD_OFF_CYCLES;
            pop         <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            pop         <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_call_argument_extractor_core NOT OK");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        ch   <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic feed_text();
        foreach (text[i])
            send_char(text[i]);
    endtask

    task automatic write_reg(input logic [cae_pkg::CFG_SEL_W-1:0] idx,
                             input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every expected result has been popped
    task automatic settle_block();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // argument character, blanks favored, never a delimiter
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? cae_pkg::CH_SPACE : cae_pkg::CH_TAB;
        do
            c = 8'($urandom_range(1, 255));
        while (c == cae_pkg::CH_COMMA || c == cae_pkg::CH_RPAREN ||
               c == cae_pkg::CH_DQUOTE || c == cae_pkg::CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] quoted_char(input logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == q);
        return c;
    endfunction

    // build one random string: mostly name(args...) with random content
    task automatic make_text();
        int kind;
        int n;
        int nargs;
        int len;
        int ending;
        logic [7:0] q;
        text.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // noise
            n = $urandom_range(1, 12);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind == 1)
        begin
            // bare name without parenthesis
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
        end
        else
        begin
            n = $urandom_range(0, 4);
            repeat (n) text.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
            text.push_back(cae_pkg::CH_LPAREN);
            nargs = $urandom_range(1, 5);
            for (int a = 0; a < nargs; a++)
            begin
                repeat ($urandom_range(0, 2))
                    text.push_back($urandom_range(0, 1) ? cae_pkg::CH_SPACE : cae_pkg::CH_TAB);
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        q = $urandom_range(0, 1) ? cae_pkg::CH_DQUOTE : cae_pkg::CH_SQUOTE;
                        text.push_back(q);
                        repeat ($urandom_range(0, 5)) text.push_back(quoted_char(q));
                        text.push_back(q);
                    end
                    else
                    begin
                        len = ($urandom_range(0, 14) == 0) ? 70 : $urandom_range(1, 5);
                        repeat (len) text.push_back(plain_char());
                    end
                end
                repeat ($urandom_range(0, 2))
                    text.push_back($urandom_range(0, 1) ? cae_pkg::CH_SPACE : cae_pkg::CH_TAB);
                if (a < nargs - 1)
                    text.push_back(cae_pkg::CH_COMMA);
            end
            // close, leave open, or leave a quote open
            ending = $urandom_range(0, 9);
            if (ending < 8)
                text.push_back(cae_pkg::CH_RPAREN);
            else if (ending == 9)
            begin
                text.push_back(cae_pkg::CH_DQUOTE);
                repeat (2) text.push_back(quoted_char(cae_pkg::CH_DQUOTE));
            end
        end
        // trailing characters, ignored once the parse has finished
        repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(1, 255)));
        text.push_back(cae_pkg::CH_NUL);
    endtask

    task automatic run_setting(input logic [7:0] idx, input logic [7:0] lim,
                               input logic hold);
        int sent;
        sent = 0;
        settle_block();
        write_reg(cae_pkg::CFG_ARG_INDEX, idx);
        write_reg(cae_pkg::CFG_ARG_LIMIT, lim);
        if (hold)
        begin
            // long result stall while a two-character drain is under way
            hold_req++;
            text = {cae_pkg::CH_LPAREN, CH_LOWER_X, CH_LOWER_Y, cae_pkg::CH_RPAREN,
                    cae_pkg::CH_NUL};
            feed_text();
        end
        while (sent < PHASE_ITEMS)
        begin
            make_text();
            feed_text();
            sent += text.size();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        ch        = cae_pkg::CH_NUL;
        cfg_valid = 1'b0;
        cfg_index = cae_pkg::CFG_ARG_INDEX;
        cfg_data  = '0;
        send_idle = 38;
        recv_idle = 83;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes to indexes outside the list must change nothing
        write_reg(CFG_SPARE_A, CH_MAX);
        write_reg(CFG_SPARE_B, CH_MIN);

        // no open parenthesis
        text = {CH_LOWER_A, CH_LOWER_Y, cae_pkg::CH_NUL};
        feed_text();
        // empty argument list
        text = {cae_pkg::CH_LPAREN, cae_pkg::CH_RPAREN, cae_pkg::CH_NUL};
        feed_text();
        // blanks stripped, quoted comma and paren kept, comma finishes, tail ignored
        text = {cae_pkg::CH_LPAREN, cae_pkg::CH_TAB, CH_MAX, cae_pkg::CH_SPACE,
                cae_pkg::CH_DQUOTE, CH_LOWER_X, cae_pkg::CH_COMMA, cae_pkg::CH_RPAREN,
                cae_pkg::CH_DQUOTE, cae_pkg::CH_SPACE, cae_pkg::CH_COMMA, CH_LOWER_Y,
                cae_pkg::CH_NUL};
        feed_text();
        // terminator inside a single quote
        text = {cae_pkg::CH_LPAREN, cae_pkg::CH_SQUOTE, CH_LOWER_A, cae_pkg::CH_NUL};
        feed_text();
        // terminator inside the parentheses
        text = {cae_pkg::CH_LPAREN, CH_MIN, cae_pkg::CH_NUL};
        feed_text();

        // sender idles less than receiver
        run_setting(8'd2, 8'd5, 1'b0);
        run_setting(8'd0, CH_MAX, 1'b0);

        // receiver idles less than sender
        send_idle = 83;
        recv_idle = 38;
        run_setting(8'd3, 8'd1, 1'b0);
        run_setting(8'd255, 8'd0, 1'b0);

        // full rate, with a long result stall first
        send_idle = 0;
        recv_idle = 0;
        run_setting(8'd1, 8'd64, 1'b1);
        run_setting(8'd1, 8'd2, 1'b0);

        settle_block();
        if (fail_count == 0)
            $display("tb_call_argument_extractor_core OK");
        else
            $display("tb_call_argument_extractor_core NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/cae_pkg.sv
rtl/cae_front.sv
rtl/cae_jobq.sv
rtl/cae_back.sv
rtl/call_argument_extractor_core.sv
dv/cae_arg_checker.sv
dv/tb_call_argument_extractor_core.sv
